// File: rtl/infix_to_postfix_converter_assert.svh
// Assertion macros for the infix to postfix converter checker.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while arst_n is low.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define IPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types, character codes and helper functions for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package ipc_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	// Character codes
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;

	// Request kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_PAREN    = 2'd2;
	localparam logic [1:0] ERR_INVALID  = 2'd3;

	// Precedence levels; zero means not an operator ('(' included)
	localparam logic [1:0] PREC_NONE = 2'd0;
	localparam logic [1:0] PREC_ADD  = 2'd1;
	localparam logic [1:0] PREC_MUL  = 2'd2;
	localparam logic [1:0] PREC_POW  = 2'd3;

	typedef struct packed {
		logic       kind;
		logic [7:0] symbol;
	} item_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       has_symbol;
		logic [1:0] error_code;
		logic       expression_done;
		logic       last;
	} result_t;

	// Result waiting for its last flag
	typedef struct packed {
		logic [7:0] out_symbol;
		logic       has_symbol;
		logic [1:0] error_code;
		logic       expression_done;
	} pend_t;

	typedef struct packed {
		logic  stage;
		logic  close;
		pend_t data;
	} buf_ctl_t;

	typedef struct packed {
		logic room;
	} buf_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TERM,
		ST_FINAL
	} state_t;

	typedef enum logic [1:0] {
		MODE_FLUSH,
		MODE_CLOSE,
		MODE_OPER
	} mode_t;

	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		case (c)
			CH_PLUS, CH_MINUS:          p = PREC_ADD;
			CH_STAR, CH_SLASH, CH_PCT:  p = PREC_MUL;
			CH_CARET:                   p = PREC_POW;
			default:                    p = PREC_NONE;
		endcase
		return p;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return c inside {[CH_0:CH_9], [CH_UA:CH_UZ], [CH_LA:CH_LZ]};
	endfunction

	function automatic pend_t mk_sym(input logic [7:0] c);
		pend_t r;
		r.out_symbol      = c;
		r.has_symbol      = 1'b1;
		r.error_code      = ERR_NONE;
		r.expression_done = 1'b0;
		return r;
	endfunction

	function automatic pend_t mk_status(input logic [1:0] err, input logic done);
		pend_t r;
		r.out_symbol      = 8'h00;
		r.has_symbol      = 1'b0;
		r.error_code      = err;
		r.expression_done = done;
		return r;
	endfunction

endpackage

// File: rtl/ipc_stack_mem.sv
// ----------------------------------------------------------------------------
// ipc_stack_mem
// Operator stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ipc_stack_mem #(
	parameter int DEPTH = ipc_pkg::STACK_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	// Write entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read entry; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/ipc_res_buf.sv
// ----------------------------------------------------------------------------
// ipc_res_buf
// Result staging: one pending slot that waits until its last flag is known,
// then an output register toward the result channel.
// ----------------------------------------------------------------------------
module ipc_res_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  ipc_pkg::buf_ctl_t ctl,
	output ipc_pkg::buf_sts_t sts,
	output logic              result_valid,
	input  logic              result_ready,
	output ipc_pkg::result_t  result
);

	logic           pend_v_q;
	ipc_pkg::pend_t pend_q;
	logic           out_v_q;
	logic           out_free;
	logic           load_out;
	logic           load_last;

	assign out_free  = !out_v_q || result_ready;
	assign sts.room  = !pend_v_q || out_free;
	assign load_out  = pend_v_q && (ctl.stage || ctl.close);
	assign load_last = ctl.close && !ctl.stage;

	// Track slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
			if (ctl.stage) begin
				pend_v_q <= 1'b1;
			end else if (ctl.close) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Move payloads
	always_ff @(posedge clk) begin
		if (ctl.stage) begin
			pend_q <= ctl.data;
		end
		if (load_out) begin
			result.out_symbol      <= pend_q.out_symbol;
			result.has_symbol      <= pend_q.has_symbol;
			result.error_code      <= pend_q.error_code;
			result.expression_done <= pend_q.expression_done;
			result.last            <= load_last;
		end
	end

	assign result_valid = out_v_q;

endmodule

// File: rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream into postfix
// characters, with the operator stack held in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel  handshake                    payload            dir
//  item     item_valid / item_ready      ipc_pkg::item_t    request in
//  result   result_valid / result_ready  ipc_pkg::result_t  request out
//
//  A request is taken only while the sequencer is idle. A push or an ignored
//  character completes there; a symbol, a plain error, or an end request on an
//  empty stack or after an error goes to ST_FINAL. ')', operators on a non-empty
//  stack and other end requests read the stack in ST_CHECK, one registered read
//  per entry popped, then ST_TERM if a flush or ')' empties it, then ST_FINAL.
//  Reset is asynchronous and leaves an empty stack; no clearing pass.
//  A stalled result channel stalls the sequencer once both result slots fill.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ipc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output ipc_pkg::result_t result
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	ipc_pkg::state_t   st_q, st_d;
	ipc_pkg::mode_t    mode_q, mode_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic              err_q, err_d;
	logic [7:0]        sym_q, sym_d;
	ipc_pkg::pend_t    term_q, term_d;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [7:0]        rd_data;

	ipc_pkg::buf_ctl_t ctl;
	ipc_pkg::buf_sts_t sts;

	logic [CW-1:0]     cnt_m1;
	logic [CW-1:0]     cnt_m2;
	logic              full;
	logic              pop;

	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);
	assign full   = (cnt_q >= CW'(STACK_DEPTH));

	// Decide whether the entry just read leaves the stack
	always_comb begin
		case (mode_q)
			ipc_pkg::MODE_FLUSH,
			ipc_pkg::MODE_CLOSE: pop = (rd_data != ipc_pkg::CH_LPAREN);
			ipc_pkg::MODE_OPER:  pop = (ipc_pkg::prec_of(rd_data) >= ipc_pkg::prec_of(sym_q));
			default:             pop = 1'b0;
		endcase
	end

	// State and context registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ipc_pkg::ST_IDLE;
			cnt_q  <= '0;
			err_q  <= 1'b0;
			mode_q <= ipc_pkg::MODE_FLUSH;
		end else begin
			st_q   <= st_d;
			cnt_q  <= cnt_d;
			err_q  <= err_d;
			mode_q <= mode_d;
		end
	end

	always_ff @(posedge clk) begin
		sym_q  <= sym_d;
		term_q <= term_d;
	end

	// Sequencer: next state, stack accesses and result staging
	always_comb begin
		st_d       = st_q;
		mode_d     = mode_q;
		cnt_d      = cnt_q;
		err_d      = err_q;
		sym_d      = sym_q;
		term_d     = term_q;
		wr_en      = 1'b0;
		wr_addr    = cnt_q[AW-1:0];
		wr_data    = sym_q;
		rd_en      = 1'b0;
		rd_addr    = cnt_m1[AW-1:0];
		ctl        = '0;
		item_ready = (st_q == ipc_pkg::ST_IDLE);

		case (st_q)
			ipc_pkg::ST_IDLE: begin
				if (item_valid) begin
					sym_d   = item.symbol;
					wr_data = item.symbol;
					if (item.kind == ipc_pkg::KIND_END) begin
						// Close the expression
						if (err_q || cnt_q == '0) begin
							err_d    = 1'b0;
							cnt_d    = '0;
							ctl.stage = 1'b1;
							ctl.data = ipc_pkg::mk_status(ipc_pkg::ERR_NONE, 1'b1);
							st_d     = ipc_pkg::ST_FINAL;
						end else begin
							rd_en  = 1'b1;
							mode_d = ipc_pkg::MODE_FLUSH;
							st_d   = ipc_pkg::ST_CHECK;
						end
					end else if (err_q) begin
						// Drop characters until the end request
					end else if (ipc_pkg::is_alnum(item.symbol)) begin
						ctl.stage = 1'b1;
						ctl.data  = ipc_pkg::mk_sym(item.symbol);
						st_d      = ipc_pkg::ST_FINAL;
					end else if (item.symbol == ipc_pkg::CH_LPAREN) begin
						if (full) begin
							err_d     = 1'b1;
							ctl.stage = 1'b1;
							ctl.data  = ipc_pkg::mk_status(ipc_pkg::ERR_OVERFLOW, 1'b0);
							st_d      = ipc_pkg::ST_FINAL;
						end else begin
							wr_en = 1'b1;
							cnt_d = cnt_q + CW'(1);
						end
					end else if (item.symbol == ipc_pkg::CH_RPAREN) begin
						if (cnt_q == '0) begin
							err_d     = 1'b1;
							ctl.stage = 1'b1;
							ctl.data  = ipc_pkg::mk_status(ipc_pkg::ERR_PAREN, 1'b0);
							st_d      = ipc_pkg::ST_FINAL;
						end else begin
							rd_en  = 1'b1;
							mode_d = ipc_pkg::MODE_CLOSE;
							st_d   = ipc_pkg::ST_CHECK;
						end
					end else if (ipc_pkg::prec_of(item.symbol) != ipc_pkg::PREC_NONE) begin
						if (cnt_q == '0) begin
							wr_en = 1'b1;
							cnt_d = cnt_q + CW'(1);
						end else begin
							rd_en  = 1'b1;
							mode_d = ipc_pkg::MODE_OPER;
							st_d   = ipc_pkg::ST_CHECK;
						end
					end else if (item.symbol == ipc_pkg::CH_SPACE ||
						     item.symbol == ipc_pkg::CH_NL) begin
						// Ignore white space
					end else begin
						err_d     = 1'b1;
						ctl.stage = 1'b1;
						ctl.data  = ipc_pkg::mk_status(ipc_pkg::ERR_INVALID, 1'b0);
						st_d      = ipc_pkg::ST_FINAL;
					end
				end
			end

			ipc_pkg::ST_CHECK: begin
				// Hold the read entry until a result slot frees up
				if (sts.room) begin
					if (pop) begin
						ctl.stage = 1'b1;
						ctl.data  = ipc_pkg::mk_sym(rd_data);
						cnt_d     = cnt_m1;
						if (cnt_q == CW'(1)) begin
							case (mode_q)
								ipc_pkg::MODE_FLUSH: begin
									term_d = ipc_pkg::mk_status(ipc_pkg::ERR_NONE, 1'b1);
									st_d   = ipc_pkg::ST_TERM;
								end
								ipc_pkg::MODE_CLOSE: begin
									err_d  = 1'b1;
									term_d = ipc_pkg::mk_status(ipc_pkg::ERR_PAREN, 1'b0);
									st_d   = ipc_pkg::ST_TERM;
								end
								default: begin
									// Push the operator onto the emptied stack
									wr_en   = 1'b1;
									wr_addr = cnt_m1[AW-1:0];
									cnt_d   = cnt_q;
									st_d    = ipc_pkg::ST_FINAL;
								end
							endcase
						end else begin
							rd_en   = 1'b1;
							rd_addr = cnt_m2[AW-1:0];
						end
					end else begin
						case (mode_q)
							ipc_pkg::MODE_FLUSH: begin
								// Unmatched '(' at flush
								cnt_d     = '0;
								ctl.stage = 1'b1;
								ctl.data  = ipc_pkg::mk_status(ipc_pkg::ERR_PAREN, 1'b1);
							end
							ipc_pkg::MODE_CLOSE: begin
								// Drop the matching '('
								cnt_d = cnt_m1;
							end
							default: begin
								if (full) begin
									err_d     = 1'b1;
									ctl.stage = 1'b1;
									ctl.data  = ipc_pkg::mk_status(ipc_pkg::ERR_OVERFLOW, 1'b0);
								end else begin
									wr_en = 1'b1;
									cnt_d = cnt_q + CW'(1);
								end
							end
						endcase
						st_d = ipc_pkg::ST_FINAL;
					end
				end
			end

			ipc_pkg::ST_TERM: begin
				if (sts.room) begin
					ctl.stage = 1'b1;
					ctl.data  = term_q;
					st_d      = ipc_pkg::ST_FINAL;
				end
			end

			ipc_pkg::ST_FINAL: begin
				// Release the pending result as the last one of this request
				if (sts.room) begin
					ctl.close = 1'b1;
					st_d      = ipc_pkg::ST_IDLE;
				end
			end

			default: begin
				st_d = ipc_pkg::ST_IDLE;
			end
		endcase
	end

	ipc_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ipc_res_buf u_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: rtl/ipc_checker.sv
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks on the result channel of the infix to postfix converter.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_assert.svh"

module ipc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input ipc_pkg::result_t result
);

	// Status results carry no character
	`IPC_ASSERT_NOW(a_nosym_zero, result_valid && !result.has_symbol, result.out_symbol == 8'h00, "status result carries a symbol byte")

	// Characters are never flagged
	`IPC_ASSERT_NOW(a_sym_clean, result_valid && result.has_symbol, result.error_code == ipc_pkg::ERR_NONE && !result.expression_done, "symbol result carries status")

	// A flush always ends its request
	`IPC_ASSERT_NOW(a_done_last, result_valid && result.expression_done, result.last, "flush close is not last")

	// An error ends its request
	`IPC_ASSERT_NOW(a_err_last, result_valid && result.error_code != ipc_pkg::ERR_NONE, result.last, "error result is not last")

	// Hold a stalled result
	`IPC_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")

endmodule

bind infix_to_postfix_converter ipc_checker u_ipc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
